@@ hw/rtl/htsed_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the HTML tag strip / entity decode unit:
// special characters and the named-entity tables. No dependencies.
package htsed_pkg;

    localparam int MAX_ENTITY_DEF = 16;
    localparam int ENT_N          = 11;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;

    // Entity bodies without '&' and ';', zero padded to eight characters
    localparam logic [7:0] ENT_NAME [ENT_N][8] = '{
        '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}, // nbsp
        '{8'h65, 8'h6E, 8'h73, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}, // ensp
        '{8'h65, 8'h6D, 8'h73, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}, // emsp
        '{8'h6C, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // lt
        '{8'h67, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // gt
        '{8'h61, 8'h6D, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // amp
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00}, // quot
        '{8'h63, 8'h6F, 8'h70, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00}, // copy
        '{8'h72, 8'h65, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // reg
        '{8'h74, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00}, // times
        '{8'h64, 8'h69, 8'h76, 8'h69, 8'h64, 8'h65, 8'h00, 8'h00}  // divide
    };

    localparam logic [2:0] ENT_LEN [ENT_N] = '{
        3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd5, 3'd6
    };

    // UTF-8 encoding, first byte in [23:16]
    localparam logic [23:0] ENT_CODE [ENT_N] = '{
        24'hC2A000, 24'hE28082, 24'hE28083, 24'h3C0000, 24'h3E0000, 24'h260000,
        24'h220000, 24'hC2A900, 24'hC2AE00, 24'hC39700, 24'hC3B700
    };

    localparam logic [1:0] ENT_CLEN [ENT_N] = '{
        2'd2, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2
    };

endpackage

@@ hw/rtl/html_tag_strip_entity_decode_unit.sv @@
`timescale 1ns / 1ps
// HTML tag strip / entity decode unit: input word register, single-pass decode,
// result sequencer with the entity run buffer, and an output word register.
// Depends on htsed_pkg.
//
// Throughput: one input word per cycle while each word yields at most one result
// and the output is not stalled. A word yielding N results (N <= MAX_ENTITY+1)
// holds the sequencer while the entity run buffer drains; input stalls then.
// Reset (i_rst_n low, synchronous): outside a tag, trimming, no run, all stages empty.
// The run buffer contents are not cleared; only entries written by the open run are read.
module html_tag_strip_entity_decode_unit #(
    parameter int MAX_ENTITY = htsed_pkg::MAX_ENTITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_empty,
    output logic       o_out_last
);
    import htsed_pkg::*;

    localparam int CW = $clog2(MAX_ENTITY + 1);  // run length 0..MAX_ENTITY
    localparam int PW = $clog2(MAX_ENTITY);      // buffer index

    // Entity stage working record: run state plus the results planned for one word.
    // Results always go out as "flush of the buffered run" followed by up to three literals.
    typedef struct packed {
        logic             in_ent;
        logic [CW-1:0]    cnt;
        logic [ENT_N-1:0] cand;     // entities still matching the run so far
        logic             started;  // run opened by this word, nothing stored yet
        logic             wr;
        logic [PW-1:0]    wr_idx;
        logic [7:0]       wr_data;
        logic [CW-1:0]    flush;
        logic [3:0][7:0]  lits;
        logic [1:0]       nlit;
    } t_est;

    function automatic t_est lit_push(input t_est s_in, input logic [7:0] x);
        t_est s;
        s = s_in;
        s.lits[s.nlit] = x;
        s.nlit         = s.nlit + 2'd1;
        return s;
    endfunction

    function automatic t_est ent_stage(input t_est s_in, input logic [7:0] x);
        t_est          s;
        logic          hit;
        logic [23:0]   code;
        logic [1:0]    clen;
        logic [CW-1:0] pos;
        s    = s_in;
        hit  = 1'b0;
        code = '0;
        clen = '0;
        pos  = s.cnt - CW'(1);
        if (s.in_ent && x == CH_SEMI) begin
            // body length is cnt-1; a surviving candidate of that length is a hit
            for (int k = 0; k < ENT_N; k++) begin
                if (s.cand[k] && pos == CW'(ENT_LEN[k])) begin
                    hit  = 1'b1;
                    code = ENT_CODE[k];
                    clen = ENT_CLEN[k];
                end
            end
            if (hit) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < clen) begin
                        s = lit_push(s, code[23-8*i -: 8]);
                    end
                end
            end else begin
                s.flush = s.cnt;
                s       = lit_push(s, CH_SEMI);
            end
            s.in_ent = 1'b0;
            s.cnt    = '0;
        end else if (s.in_ent && s.cnt < CW'(MAX_ENTITY)) begin
            for (int k = 0; k < ENT_N; k++) begin
                s.cand[k] = s.cand[k] && (pos < CW'(ENT_LEN[k])) &&
                            (ENT_NAME[k][pos[2:0]] == x);
            end
            s.wr      = 1'b1;
            s.wr_idx  = s.cnt[PW-1:0];
            s.wr_data = x;
            s.cnt     = s.cnt + CW'(1);
        end else begin
            // full run: drop it out literally, then take x as fresh text
            if (s.in_ent) begin
                s.flush  = s.cnt;
                s.in_ent = 1'b0;
                s.cnt    = '0;
            end
            if (x == CH_AMP) begin
                s.in_ent  = 1'b1;
                s.cnt     = CW'(1);
                s.cand    = '1;
                s.started = 1'b1;
            end else begin
                s = lit_push(s, x);
            end
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input word register
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       take;       // decode the held word into the sequencer this cycle

    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // ------------------------------------------------------------------
    // Document state
    // ------------------------------------------------------------------
    logic             r_text, r_trim, r_crp, r_in_ent;
    logic [CW-1:0]    r_cnt;
    logic [ENT_N-1:0] r_cand;

    logic n_text, n_trim, n_crp, n_empty;
    t_est est;

    // Single pass over one word: tag filter, leading trim, entity stage, end of document
    always_comb begin
        est = '{in_ent: r_in_ent, cnt: r_cnt, cand: r_cand, default: '0};
        n_text  = r_text;
        n_trim  = r_trim;
        n_crp   = r_crp;
        n_empty = 1'b0;

        if (r_in_byte == CH_LT) begin
            n_text = 1'b0;
        end else if (r_in_byte == CH_GT) begin
            n_text = 1'b1;
        end else if (r_text) begin
            if (!r_trim) begin
                est = ent_stage(est, r_in_byte);
            end else if (r_crp) begin
                // CR-LF pair is trimmed; a lone CR ends trimming and goes out
                n_crp = 1'b0;
                if (r_in_byte != CH_LF) begin
                    n_trim = 1'b0;
                    est    = ent_stage(est, CH_CR);
                    est    = ent_stage(est, r_in_byte);
                end
            end else if (r_in_byte == CH_CR) begin
                n_crp = 1'b1;
            end else if (r_in_byte != CH_SP) begin
                n_trim = 1'b0;
                est    = ent_stage(est, r_in_byte);
            end
        end

        if (r_in_last) begin
            if (n_crp) begin
                est = ent_stage(est, CH_CR);
            end
            if (est.in_ent) begin
                if (est.wr) begin
                    // byte just appended: send the older part from the buffer,
                    // this byte as a literal, and skip the write
                    est.wr    = 1'b0;
                    est.flush = est.cnt - CW'(1);
                    est       = lit_push(est, est.wr_data);
                end else if (est.started) begin
                    est = lit_push(est, CH_AMP);
                end else begin
                    est.flush = est.cnt;
                end
            end
            if (est.flush == '0 && est.nlit == 2'd0) begin
                n_empty = 1'b1;
                est     = lit_push(est, 8'h00);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text   <= 1'b1;
            r_trim   <= 1'b1;
            r_crp    <= 1'b0;
            r_in_ent <= 1'b0;
            r_cnt    <= '0;
            r_cand   <= '0;
        end else if (take) begin
            if (r_in_last) begin
                r_text   <= 1'b1;
                r_trim   <= 1'b1;
                r_crp    <= 1'b0;
                r_in_ent <= 1'b0;
                r_cnt    <= '0;
            end else begin
                r_text   <= n_text;
                r_trim   <= n_trim;
                r_crp    <= n_crp;
                r_in_ent <= est.in_ent;
                r_cnt    <= est.cnt;
            end
            r_cand <= est.cand;
        end
    end

    // ------------------------------------------------------------------
    // Entity run buffer. Entry 0 always holds '&', so it is never written
    // and reads of it are replaced by the constant.
    // ------------------------------------------------------------------
    logic [7:0]    mem [MAX_ENTITY];
    logic [7:0]    r_rd;
    logic [PW-1:0] r_fl_ptr, n_fl_ptr;

    always_ff @(posedge i_clk) begin
        if (take && est.wr) begin
            mem[est.wr_idx] <= est.wr_data;
        end
    end

    // read one entry ahead so r_rd always holds mem[r_fl_ptr]
    always_ff @(posedge i_clk) begin
        r_rd <= mem[n_fl_ptr];
    end

    // ------------------------------------------------------------------
    // Result sequencer: buffered run first, then the literal bytes
    // ------------------------------------------------------------------
    logic [CW-1:0]   r_fl_cnt;
    logic [3:0][7:0] r_lit;
    logic [1:0]      r_lit_cnt;
    logic            r_job_last, r_job_empty;

    logic       seq_has, seq_single, adv, out_load;
    logic [7:0] seq_byte;

    assign seq_has    = (r_fl_cnt != '0) || (r_lit_cnt != 2'd0);
    assign seq_single = (r_fl_cnt == '0 && r_lit_cnt <= 2'd1) ||
                        (r_fl_cnt == CW'(1) && r_lit_cnt == 2'd0);
    assign out_load   = !o_valid || i_ready;
    assign adv        = seq_has && out_load;
    assign take       = r_in_valid && (!seq_has || (seq_single && adv));
    assign seq_byte   = (r_fl_cnt != '0) ? ((r_fl_ptr == '0) ? CH_AMP : r_rd) : r_lit[0];

    always_comb begin
        if (take) begin
            n_fl_ptr = '0;
        end else if (adv && r_fl_cnt != '0) begin
            n_fl_ptr = r_fl_ptr + PW'(1);
        end else begin
            n_fl_ptr = r_fl_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl_cnt    <= '0;
            r_lit_cnt   <= 2'd0;
            r_fl_ptr    <= '0;
            r_job_last  <= 1'b0;
            r_job_empty <= 1'b0;
        end else begin
            r_fl_ptr <= n_fl_ptr;
            if (take) begin
                r_fl_cnt    <= est.flush;
                r_lit_cnt   <= est.nlit;
                r_job_last  <= r_in_last;
                r_job_empty <= n_empty;
            end else if (adv) begin
                if (r_fl_cnt != '0) begin
                    r_fl_cnt <= r_fl_cnt - CW'(1);
                end else begin
                    r_lit_cnt <= r_lit_cnt - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_lit <= est.lits;
        end else if (adv && r_fl_cnt == '0) begin
            r_lit <= {8'h00, r_lit[3:1]};
        end
    end

    // ------------------------------------------------------------------
    // Output word register
    // ------------------------------------------------------------------
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_empty, r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= seq_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_byte  <= seq_byte;
            r_o_empty <= r_job_empty;
            r_o_last  <= r_job_last && seq_single;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_out_empty = r_o_empty;
    assign o_out_last  = r_o_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ent |-> (r_cnt != '0) && (r_cnt <= CW'(MAX_ENTITY)))
        else $error("open run has bad length");

    a_no_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_ent |-> (r_cnt == '0))
        else $error("length left over without an open run");

    a_doc_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_last |=> r_text && r_trim && !r_crp && !r_in_ent)
        else $error("state not back to start after end of document");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl_cnt <= CW'(MAX_ENTITY))
        else $error("flush longer than the run buffer");

    a_no_write_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fl_cnt > CW'(1)) |-> !(take && est.wr))
        else $error("run buffer written while it drains");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for html_tag_strip_entity_decode_unit: feeds HTML documents one word at a time
// and checks every output word against a predicted stream of stripped, decoded text.
// Depends on htsed_pkg and the unit itself.
module tb;
    import htsed_pkg::*;

    localparam int RUN_DEPTH   = MAX_ENTITY_DEF;
    localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either channel
    localparam int HOLD_CYCLES = 240;   // long receiver hold-off in the first random phase
    localparam int PHASE_WORDS = 100;   // input words per random phase, roughly

    typedef struct packed {
        logic [7:0] text_byte;
        logic       empty;
        logic       last;
    } t_text_word;

    // Tracks tag, trim and entity-run state of the current document and keeps the
    // text words the unit still owes, oldest first.
    class plain_text_board;
        t_text_word expected_text[$];
        int         fault_count;
        bit         in_text;
        bit         trimming;
        bit         cr_seen;
        bit         run_open;
        logic [7:0] run_bytes [RUN_DEPTH];
        int         run_len;
        int         step_words;

        function new();
            fault_count = 0;
            restart();
        endfunction

        function void restart();
            in_text  = 1'b1;
            trimming = 1'b1;
            cr_seen  = 1'b0;
            run_open = 1'b0;
            run_len  = 0;
        endfunction

        function void push_text(logic [7:0] b);
            t_text_word w;
            if (step_words < RUN_DEPTH + 2) begin
                w = '{b, 1'b0, 1'b0};
                expected_text.push_back(w);
                step_words++;
            end
        endfunction

        // Emit the buffered run as it came in and close it.
        function void flush_run();
            int i;
            for (i = 0; i < run_len; i++) push_text(run_bytes[i]);
            run_open = 1'b0;
            run_len  = 0;
        endfunction

        // A ';' arrived: decode a known name, else pass the run and the ';' through.
        function void close_run();
            logic [47:0] key;
            logic [23:0] utf;
            int          ulen;
            int          body;
            int          i;
            key  = '0;
            utf  = '0;
            ulen = 0;
            body = run_len - 1;
            if (body >= 2 && body <= 6)
                for (i = 1; i < run_len; i++) key = {key[39:0], run_bytes[i]};
            case (1'b1)
                body == 4 && key == "nbsp":   begin utf = 24'hC2A000; ulen = 2; end
                body == 4 && key == "ensp":   begin utf = 24'hE28082; ulen = 3; end
                body == 4 && key == "emsp":   begin utf = 24'hE28083; ulen = 3; end
                body == 2 && key == "lt":     begin utf = 24'h3C0000; ulen = 1; end
                body == 2 && key == "gt":     begin utf = 24'h3E0000; ulen = 1; end
                body == 3 && key == "amp":    begin utf = 24'h260000; ulen = 1; end
                body == 4 && key == "quot":   begin utf = 24'h220000; ulen = 1; end
                body == 4 && key == "copy":   begin utf = 24'hC2A900; ulen = 2; end
                body == 3 && key == "reg":    begin utf = 24'hC2AE00; ulen = 2; end
                body == 5 && key == "times":  begin utf = 24'hC39700; ulen = 2; end
                body == 6 && key == "divide": begin utf = 24'hC3B700; ulen = 2; end
                default: ;
            endcase
            if (ulen > 0) begin
                for (i = 0; i < ulen; i++) push_text(utf[23 - 8 * i -: 8]);
                run_open = 1'b0;
                run_len  = 0;
            end else begin
                flush_run();
                push_text(CH_SEMI);
            end
        endfunction

        function void run_stage(logic [7:0] b);
            if (run_open) begin
                if (b == CH_SEMI) begin
                    close_run();
                    return;
                end
                if (run_len < RUN_DEPTH) begin
                    run_bytes[run_len] = b;
                    run_len++;
                    return;
                end
                // buffer full: flush, then treat this byte as fresh text
                flush_run();
            end
            if (b == CH_AMP) begin
                run_open     = 1'b1;
                run_bytes[0] = b;
                run_len      = 1;
            end else begin
                push_text(b);
            end
        endfunction

        // Drop leading spaces and CR-LF pairs; a lone CR ends trimming and is kept.
        function void lead_stage(logic [7:0] b);
            if (!trimming) begin
                run_stage(b);
                return;
            end
            if (cr_seen) begin
                cr_seen = 1'b0;
                if (b == CH_LF) return;
                trimming = 1'b0;
                run_stage(CH_CR);
                run_stage(b);
                return;
            end
            if (b == CH_CR) begin
                cr_seen = 1'b1;
            end else if (b != CH_SP) begin
                trimming = 1'b0;
                run_stage(b);
            end
        endfunction

        function void note_html_word(logic [7:0] b, logic last);
            t_text_word w;
            step_words = 0;
            if (b == CH_LT) in_text = 1'b0;
            else if (b == CH_GT) in_text = 1'b1;
            else if (in_text) lead_stage(b);
            if (last) begin
                if (cr_seen) begin
                    cr_seen  = 1'b0;
                    trimming = 1'b0;
                    run_stage(CH_CR);
                end
                if (run_open) flush_run();
                if (step_words == 0) begin
                    w = '{8'h00, 1'b1, 1'b1};
                    expected_text.push_back(w);
                end else begin
                    expected_text[expected_text.size() - 1].last = 1'b1;
                end
                restart();
            end
        endfunction

        function void check_text_word(logic [7:0] b, logic empty, logic last);
            t_text_word want;
            if (expected_text.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected text word byte=%02h empty=%0b last=%0b",
                         $time, b, empty, last);
                return;
            end
            want = expected_text.pop_front();
            if (want.text_byte !== b) begin
                fault_count++;
                $display("%0t: out_byte expected %02h actual %02h", $time, want.text_byte, b);
            end
            if (want.empty !== empty) begin
                fault_count++;
                $display("%0t: out_empty expected %0b actual %0b", $time, want.empty, empty);
            end
            if (want.last !== last) begin
                fault_count++;
                $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
            end
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_empty;
    logic       o_out_last;

    plain_text_board board;
    logic [7:0]      doc_bytes[$];   // document being assembled for the sender
    int              tx_idle_pct  = 0;
    int              rx_stall_pct = 0;
    bit              hold_request = 1'b0;
    int              hold_left    = 0;
    int              quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    html_tag_strip_entity_decode_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_empty(o_out_empty),
        .o_out_last (o_out_last)
    );

    // Receiver: stall at the phase rate; on request, hold ready low for a long
    // stretch so the unit backs up and stalls its input.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check every output word taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_text_word(o_out_byte, o_out_empty, o_out_last);
    end

    // Watchdog: end the run if no word moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one word, idling first at the phase rate; hold it until accepted.
    task automatic send_html_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_html_word(b, last);
    endtask

    task automatic send_document();
        int i;
        for (i = 0; i < doc_bytes.size(); i++)
            send_html_word(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    // Stop offering and wait for every owed text word, then let the pipe settle.
    task automatic drain_text();
        i_valid <= 1'b0;
        while (board.expected_text.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic void add_tag();
        int n;
        n = $urandom_range(5);
        doc_bytes.push_back(CH_LT);
        repeat (n) doc_bytes.push_back(pick_text_byte());
        if ($urandom_range(9) != 0) doc_bytes.push_back(CH_GT);
    endfunction

    function automatic void add_blank();
        case ($urandom_range(3))
            0: doc_bytes.push_back(CH_SP);
            1: doc_bytes.push_back(CH_CR);
            2: doc_bytes.push_back(CH_LF);
            default: begin
                doc_bytes.push_back(CH_CR);
                doc_bytes.push_back(CH_LF);
            end
        endcase
    endfunction

    // Well-formed named entity, now and then split by a tag.
    function automatic void add_entity();
        string name;
        int    i;
        case ($urandom_range(10))
            0: name = "nbsp";
            1: name = "ensp";
            2: name = "emsp";
            3: name = "lt";
            4: name = "gt";
            5: name = "amp";
            6: name = "quot";
            7: name = "copy";
            8: name = "reg";
            9: name = "times";
            default: name = "divide";
        endcase
        doc_bytes.push_back(CH_AMP);
        for (i = 0; i < name.len(); i++) begin
            doc_bytes.push_back(name[i]);
            if (i == 0 && $urandom_range(9) == 0) add_tag();
        end
        doc_bytes.push_back(CH_SEMI);
    endfunction

    // Unknown or broken run: short bodies, and long ones that reach a full buffer.
    function automatic void add_bogus_run();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1) ? $urandom_range(0, 6) : $urandom_range(13, 18);
        doc_bytes.push_back(CH_AMP);
        repeat (n) begin
            if ($urandom_range(5) == 0) begin
                b = 8'($urandom_range(255));
                if (b == CH_SEMI) b = CH_AMP;
            end else begin
                b = 8'($urandom_range(8'h61, 8'h7A));
            end
            doc_bytes.push_back(b);
        end
        if ($urandom_range(9) < 6) doc_bytes.push_back(CH_SEMI);
    endfunction

    function automatic void build_document();
        int frags;
        doc_bytes.delete();
        // leading whitespace and tags exercise the trim logic
        if ($urandom_range(2) != 0)
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(2) == 0) add_tag();
                else add_blank();
            end
        frags = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8);
        repeat (frags) begin
            case ($urandom_range(9))
                0, 1, 2: repeat ($urandom_range(1, 4)) doc_bytes.push_back(pick_text_byte());
                3, 4, 5: add_entity();
                6:       add_bogus_run();
                7:       add_tag();
                8:       add_blank();
                default: begin
                    case ($urandom_range(2))
                        0: doc_bytes.push_back(CH_AMP);
                        1: doc_bytes.push_back(CH_SEMI);
                        default: doc_bytes.push_back(CH_GT);
                    endcase
                end
            endcase
        end
        if (doc_bytes.size() == 0) doc_bytes.push_back(CH_SP);
    endfunction

    initial begin
        int phase;
        int sent;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed documents.
        // Lone '<' at end of document: nothing produced, one empty word.
        doc_bytes = '{CH_LT};
        send_document();
        // Leading space, CR-LF split by a tag, then the empty run "&;".
        doc_bytes = '{CH_SP, CH_CR, CH_LT, "x", CH_GT, CH_LF, "A", CH_AMP, CH_SEMI};
        send_document();
        // Lone CR ends trimming; inner '&'; unterminated run flushed at end.
        doc_bytes = '{CH_CR, "B", CH_AMP, CH_AMP, "g", "t"};
        send_document();
        // CR still pending when the document ends.
        doc_bytes = '{CH_CR};
        send_document();
        // Byte extremes; zero is ordinary text.
        doc_bytes = '{8'h00, 8'hFF};
        send_document();
        // Entity split by a tag still decodes.
        doc_bytes = '{CH_AMP, "l", CH_LT, "i", CH_GT, "t", CH_SEMI};
        send_document();
        drain_text();

        // Random phases: no idling (with a long receiver hold-off at the start),
        // sender idle, receiver stalling, both.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_request = 1'b1; end
                1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            sent = 0;
            while (sent < PHASE_WORDS) begin
                build_document();
                send_document();
                sent += doc_bytes.size();
            end
            drain_text();
        end

        repeat (8) @(posedge i_clk);
        if (board.fault_count == 0 && board.expected_text.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
